FILE: src/tur_pkg.sv
// Shared constants, types and helper functions of the tile usage run extract / remap block.
package tur_pkg;

	// Sizing
	localparam int MAX_TILES    = 2048;
	localparam int MAX_PIECES   = 16;
	localparam int RESULT_LIMIT = 32;

	// Fixed field widths of the channels
	localparam int TILE_W = 11;
	localparam int WH_W   = 3;
	localparam int AREA_W = 2 * WH_W;
	localparam int KIND_W = 2;
	localparam int VA_W   = 11;
	localparam int VB_W   = 12;

	// Bitmap organization: one memory word holds WORD_W tile bits
	localparam int WORD_W  = (MAX_TILES < 32) ? MAX_TILES : 32;
	localparam int WORDS   = MAX_TILES / WORD_W;
	localparam int BIT_W   = $clog2(WORD_W);
	localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int TADDR_W = WADDR_W + BIT_W;
	localparam int RANK_W  = TADDR_W + 1;
	localparam int SPAN_W  = ((TILE_W > TADDR_W) ? TILE_W : TADDR_W) + 1;

	// Counters
	localparam int CNT_W  = $clog2(MAX_PIECES + 1);
	localparam int PIDX_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
	localparam int RC_W   = $clog2(RESULT_LIMIT);

	typedef enum logic [KIND_W-1:0] {
		KIND_RUN   = 2'd0,
		KIND_REMAP = 2'd1,
		KIND_EMPTY = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MARK_RD,
		ST_MARK_WR,
		ST_SCAN_FETCH,
		ST_SCAN_LOAD,
		ST_SCAN_RUN,
		ST_REMAP_RD,
		ST_REMAP_MAP,
		ST_REMAP_OUT,
		ST_EMPTY,
		ST_CLEAR
	} state_t;

	// Bitmap memory access request
	typedef struct packed {
		logic               rd_en;
		logic               wr_en;
		logic               clr;
		logic [WADDR_W-1:0] addr;
		logic [WORD_W-1:0]  wdata;
	} bmp_req_t;

	typedef struct packed {
		logic             hit;
		logic [BIT_W-1:0] idx;
	} find_t;

	function automatic logic [BIT_W:0] popcount(input logic [WORD_W-1:0] v);
		logic [BIT_W:0] sum;
		sum = '0;
		for (int i = 0; i < WORD_W; i++) begin
			sum = sum + (BIT_W+1)'(v[i]);
		end
		return sum;
	endfunction

	// Lowest set bit
	function automatic find_t find_first(input logic [WORD_W-1:0] v);
		find_t r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r.hit = 1'b1;
				r.idx = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// Bits strictly below position off
	function automatic logic [WORD_W-1:0] low_mask(input logic [BIT_W-1:0] off);
		logic [WORD_W-1:0] ones;
		ones = '1;
		return ~(ones << off);
	endfunction

	// Bits lo..hi inclusive
	function automatic logic [WORD_W-1:0] span_mask(input logic [BIT_W-1:0] lo,
		input logic [BIT_W-1:0] hi);
		logic [WORD_W-1:0] ones;
		ones = '1;
		return (ones << lo) & (ones >> (BIT_W'(WORD_W - 1) - hi));
	endfunction

endpackage

FILE: src/tur_if.sv
// Valid/ready channel interfaces for pieces in and results out.
interface tur_in_if;
	logic                      valid;
	logic                      ready;
	logic                      piece_valid;
	logic [tur_pkg::TILE_W-1:0] piece_tile;
	logic [tur_pkg::WH_W-1:0]   piece_width;
	logic [tur_pkg::WH_W-1:0]   piece_height;
	logic                      frame_end;

	modport source (output valid, piece_valid, piece_tile, piece_width, piece_height,
		frame_end, input ready);
	modport sink (input valid, piece_valid, piece_tile, piece_width, piece_height,
		frame_end, output ready);
endinterface

interface tur_out_if;
	logic                      valid;
	logic                      ready;
	logic [tur_pkg::KIND_W-1:0] kind;
	logic [tur_pkg::VA_W-1:0]   value_a;
	logic [tur_pkg::VB_W-1:0]   value_b;
	logic                      overflow;
	logic                      last;

	modport source (output valid, kind, value_a, value_b, overflow, last, input ready);
	modport sink (input valid, kind, value_a, value_b, overflow, last, output ready);
endinterface

FILE: src/tur_bitmap.sv
// Tile usage bitmap: word memory with per-word valid bits and registered read.
module tur_bitmap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tur_pkg::bmp_req_t            req,
	output logic [tur_pkg::WORD_W-1:0]   rdata
);

	logic [tur_pkg::WORD_W-1:0] mem [tur_pkg::WORDS];
	logic [tur_pkg::WORDS-1:0]  word_vld_q;
	logic [tur_pkg::WORD_W-1:0] rdata_q;
	logic                       rvld_q;

	// A word never written since the last clear reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rvld_q     <= 1'b0;
		end else begin
			if (req.clr) begin
				word_vld_q <= '0;
			end else if (req.wr_en) begin
				word_vld_q[req.addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rvld_q <= word_vld_q[req.addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rvld_q ? rdata_q : '0;

endmodule

FILE: src/tile_usage_run_extract_remap.sv
// Top level: sprite frame tile usage marking, run extraction and piece start remapping.
//
// Pieces of one sprite frame arrive one beat at a time; each covers width*height
// consecutive tiles from its start tile, and those tiles are set in a 2048-bit usage
// bitmap held as 64 words of 32 bits in a single-port memory. A piece beat that is
// dropped (more than 16 pieces, or tiles beyond the top of the bitmap) or covers no
// tile needs no bitmap access; otherwise each bitmap word it touches is read, then
// ORed and written back. The beat with frame_end set starts the frame-end pass: word
// 0 is fetched, then each word is loaded, with the next one prefetched, and searched
// for run edges; each run of used tiles is sent as kind 0 (start, length), and a running
// tile count per word is stored in a rank memory. Then every kept piece, in arrival
// order, is sent as kind 1 with its new start (used tiles below its old start), read
// from the piece start store, the bitmap and the rank memory. A frame sends at most 32
// results, and a frame with no kept piece gives one kind 2 beat. The last result of a
// frame carries last, and overflow is set on every result of a frame that dropped a
// piece. Result beats wait while the result side holds ready low. The bitmap is
// cleared by dropping its per-word valid bits at once, so there is no clearing pass
// after reset or between frames. A new piece beat is taken once the bitmap is cleared,
// in the cycle after the final result of the previous frame enters the output register.
module tile_usage_run_extract_remap (
	input  logic        clk,
	input  logic        arst_n,
	tur_in_if.sink      pieces,
	tur_out_if.source   results
);

	tur_pkg::state_t state_q, state_d;

	// Frame bookkeeping
	logic [tur_pkg::CNT_W-1:0]   count_q;
	logic                        dropped_q;
	logic                        end_pend_q;
	logic [tur_pkg::RC_W-1:0]    res_cnt_q;

	// Piece marking
	logic [tur_pkg::WADDR_W-1:0] wcur_q, wfirst_q, wlast_q;
	logic [tur_pkg::BIT_W-1:0]   fbit_q, lbit_q;

	// Scan
	logic [tur_pkg::WADDR_W-1:0] w_q;
	logic [tur_pkg::WORD_W-1:0]  cur_q;
	logic [tur_pkg::BIT_W-1:0]   pos_q;
	logic                        in_run_q;
	logic [tur_pkg::TADDR_W-1:0] run_start_q;
	logic [tur_pkg::RANK_W-1:0]  acc_q;

	// Remap
	logic [tur_pkg::CNT_W-1:0]   p_q;
	logic [tur_pkg::TILE_W-1:0]  ps_rd_q;
	logic [tur_pkg::BIT_W-1:0]   off_q;
	logic [tur_pkg::RANK_W-1:0]  rank_rd_q;

	// Memories local to the top level
	logic [tur_pkg::TILE_W-1:0]  pstore_mem [tur_pkg::MAX_PIECES];
	logic [tur_pkg::RANK_W-1:0]  rank_mem [tur_pkg::WORDS];

	// Output register
	logic                        out_vld_q;
	tur_pkg::kind_t              out_kind_q;
	logic [tur_pkg::VA_W-1:0]    out_a_q;
	logic [tur_pkg::VB_W-1:0]    out_b_q;
	logic                        out_ovf_q;
	logic                        out_last_q;

	logic                        out_load;
	tur_pkg::kind_t              out_kind_d;
	logic [tur_pkg::VA_W-1:0]    out_a_d;
	logic [tur_pkg::VB_W-1:0]    out_b_d;
	logic                        out_last_d;
	logic                        out_free;

	tur_pkg::bmp_req_t           bmp_req;
	logic [tur_pkg::WORD_W-1:0]  bmp_rdata;

	// Input decode
	logic                        fire;
	logic [tur_pkg::AREA_W-1:0]  area;
	logic [tur_pkg::SPAN_W-1:0]  tile_x, span_end, last_tile;
	logic                        drop;
	logic                        take_piece;
	logic                        mark_need;
	logic [tur_pkg::CNT_W-1:0]   count_nx;

	// Datapath helpers
	logic [tur_pkg::WORD_W-1:0]  mark_mask;
	logic [tur_pkg::BIT_W-1:0]   mask_lo, mask_hi;
	tur_pkg::find_t              srch;
	logic [tur_pkg::RANK_W-1:0]  run_len_mid, run_len_top;
	logic                        res_lim;
	logic                        p_final;
	logic [tur_pkg::SPAN_W-1:0]  ps_x;
	logic [tur_pkg::WADDR_W-1:0] remap_word;
	logic [tur_pkg::RANK_W-1:0]  remap_below;

	tur_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bmp_req),
		.rdata  (bmp_rdata)
	);

	assign fire       = pieces.valid && pieces.ready;
	// widen both factors first so the product keeps all six bits
	assign area       = tur_pkg::AREA_W'(pieces.piece_width) *
	                    tur_pkg::AREA_W'(pieces.piece_height);
	assign tile_x     = tur_pkg::SPAN_W'(pieces.piece_tile);
	assign span_end   = tile_x + tur_pkg::SPAN_W'(area);
	assign last_tile  = span_end - tur_pkg::SPAN_W'(1);
	assign drop       = (count_q >= tur_pkg::CNT_W'(tur_pkg::MAX_PIECES)) ||
	                    (tile_x >= tur_pkg::SPAN_W'(tur_pkg::MAX_TILES)) ||
	                    (span_end > tur_pkg::SPAN_W'(tur_pkg::MAX_TILES));
	assign take_piece = fire && pieces.piece_valid && !drop;
	assign mark_need  = take_piece && (area != '0);
	assign count_nx   = take_piece ? count_q + tur_pkg::CNT_W'(1) : count_q;

	// Bits of the current word that the piece covers
	assign mask_lo   = (wcur_q == wfirst_q) ? fbit_q : '0;
	assign mask_hi   = (wcur_q == wlast_q) ? lbit_q : tur_pkg::BIT_W'(tur_pkg::WORD_W - 1);
	assign mark_mask = tur_pkg::span_mask(mask_lo, mask_hi);

	// Next run edge at or above the cursor: a used bit outside a run, a free bit inside
	assign srch = tur_pkg::find_first((in_run_q ? ~cur_q : cur_q) &
		~tur_pkg::low_mask(pos_q));
	assign run_len_mid = tur_pkg::RANK_W'({w_q, srch.idx}) - tur_pkg::RANK_W'(run_start_q);
	assign run_len_top = tur_pkg::RANK_W'(tur_pkg::MAX_TILES) -
		tur_pkg::RANK_W'(run_start_q);

	assign res_lim = (res_cnt_q == tur_pkg::RC_W'(tur_pkg::RESULT_LIMIT - 1));
	assign p_final = (p_q == count_q - tur_pkg::CNT_W'(1));

	assign ps_x        = tur_pkg::SPAN_W'(ps_rd_q);
	assign remap_word  = ps_x[tur_pkg::TADDR_W-1:tur_pkg::BIT_W];
	assign remap_below = rank_rd_q +
		tur_pkg::RANK_W'(tur_pkg::popcount(bmp_rdata & tur_pkg::low_mask(off_q)));

	assign out_free = !out_vld_q || results.ready;

	// Next state, memory requests and result loading
	always_comb begin
		state_d    = state_q;
		bmp_req    = '0;
		out_load   = 1'b0;
		out_kind_d = tur_pkg::KIND_RUN;
		out_a_d    = '0;
		out_b_d    = '0;
		out_last_d = 1'b0;
		case (state_q)
			tur_pkg::ST_IDLE: begin
				if (fire) begin
					if (mark_need) begin
						state_d = tur_pkg::ST_MARK_RD;
					end else if (pieces.frame_end) begin
						state_d = (count_nx == '0) ? tur_pkg::ST_EMPTY : tur_pkg::ST_SCAN_FETCH;
					end
				end
			end
			tur_pkg::ST_MARK_RD: begin
				bmp_req.rd_en = 1'b1;
				bmp_req.addr  = wcur_q;
				state_d       = tur_pkg::ST_MARK_WR;
			end
			tur_pkg::ST_MARK_WR: begin
				bmp_req.wr_en = 1'b1;
				bmp_req.addr  = wcur_q;
				bmp_req.wdata = bmp_rdata | mark_mask;
				if (wcur_q == wlast_q) begin
					state_d = end_pend_q ? tur_pkg::ST_SCAN_FETCH : tur_pkg::ST_IDLE;
				end else begin
					state_d = tur_pkg::ST_MARK_RD;
				end
			end
			tur_pkg::ST_SCAN_FETCH: begin
				bmp_req.rd_en = 1'b1;
				bmp_req.addr  = '0;
				state_d       = tur_pkg::ST_SCAN_LOAD;
			end
			tur_pkg::ST_SCAN_LOAD: begin
				// prefetch the next word; the read register holds it until the current one is done
				bmp_req.rd_en = 1'b1;
				bmp_req.addr  = w_q + tur_pkg::WADDR_W'(1);
				state_d       = tur_pkg::ST_SCAN_RUN;
			end
			tur_pkg::ST_SCAN_RUN: begin
				if (srch.hit) begin
					if (in_run_q && out_free) begin
						out_load   = 1'b1;
						out_kind_d = tur_pkg::KIND_RUN;
						out_a_d    = tur_pkg::VA_W'(run_start_q);
						out_b_d    = tur_pkg::VB_W'(run_len_mid);
						out_last_d = res_lim;
						if (res_lim) begin
							state_d = tur_pkg::ST_CLEAR;
						end
					end
				end else if (w_q != tur_pkg::WADDR_W'(tur_pkg::WORDS - 1)) begin
					state_d = tur_pkg::ST_SCAN_LOAD;
				end else if (in_run_q) begin
					// run reaching the top tile ends there
					if (out_free) begin
						out_load   = 1'b1;
						out_kind_d = tur_pkg::KIND_RUN;
						out_a_d    = tur_pkg::VA_W'(run_start_q);
						out_b_d    = tur_pkg::VB_W'(run_len_top);
						out_last_d = res_lim;
						state_d    = res_lim ? tur_pkg::ST_CLEAR : tur_pkg::ST_REMAP_RD;
					end
				end else begin
					state_d = tur_pkg::ST_REMAP_RD;
				end
			end
			tur_pkg::ST_REMAP_RD: begin
				state_d = tur_pkg::ST_REMAP_MAP;
			end
			tur_pkg::ST_REMAP_MAP: begin
				bmp_req.rd_en = 1'b1;
				bmp_req.addr  = remap_word;
				state_d       = tur_pkg::ST_REMAP_OUT;
			end
			tur_pkg::ST_REMAP_OUT: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = tur_pkg::KIND_REMAP;
					out_a_d    = tur_pkg::VA_W'(remap_below);
					out_b_d    = tur_pkg::VB_W'(p_q);
					out_last_d = res_lim || p_final;
					state_d    = (res_lim || p_final) ? tur_pkg::ST_CLEAR : tur_pkg::ST_REMAP_RD;
				end
			end
			tur_pkg::ST_EMPTY: begin
				if (out_free) begin
					out_load   = 1'b1;
					out_kind_d = tur_pkg::KIND_EMPTY;
					out_last_d = 1'b1;
					state_d    = tur_pkg::ST_CLEAR;
				end
			end
			tur_pkg::ST_CLEAR: begin
				bmp_req.clr = 1'b1;
				state_d     = tur_pkg::ST_IDLE;
			end
			default: begin
				state_d = tur_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= tur_pkg::ST_IDLE;
			count_q    <= '0;
			dropped_q  <= 1'b0;
			end_pend_q <= 1'b0;
			res_cnt_q  <= '0;
			out_vld_q  <= 1'b0;
			w_q        <= '0;
			pos_q      <= '0;
			in_run_q   <= 1'b0;
			p_q        <= '0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
				res_cnt_q <= res_cnt_q + tur_pkg::RC_W'(1);
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				tur_pkg::ST_IDLE: begin
					if (fire) begin
						end_pend_q <= pieces.frame_end;
						if (pieces.piece_valid && drop) begin
							dropped_q <= 1'b1;
						end
						count_q <= count_nx;
					end
				end
				tur_pkg::ST_SCAN_FETCH: begin
					w_q      <= '0;
					in_run_q <= 1'b0;
					p_q      <= '0;
				end
				tur_pkg::ST_SCAN_LOAD: begin
					pos_q <= '0;
				end
				tur_pkg::ST_SCAN_RUN: begin
					if (srch.hit) begin
						// open a run, or close it once its beat is loaded
						if (!in_run_q || out_free) begin
							in_run_q <= !in_run_q;
							pos_q    <= srch.idx;
						end
					end else if (w_q != tur_pkg::WADDR_W'(tur_pkg::WORDS - 1)) begin
						w_q <= w_q + tur_pkg::WADDR_W'(1);
					end
				end
				tur_pkg::ST_REMAP_OUT: begin
					if (out_free) begin
						p_q <= p_q + tur_pkg::CNT_W'(1);
					end
				end
				tur_pkg::ST_CLEAR: begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					res_cnt_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			tur_pkg::ST_IDLE: begin
				if (mark_need) begin
					wfirst_q <= tile_x[tur_pkg::TADDR_W-1:tur_pkg::BIT_W];
					wcur_q   <= tile_x[tur_pkg::TADDR_W-1:tur_pkg::BIT_W];
					fbit_q   <= tile_x[tur_pkg::BIT_W-1:0];
					wlast_q  <= last_tile[tur_pkg::TADDR_W-1:tur_pkg::BIT_W];
					lbit_q   <= last_tile[tur_pkg::BIT_W-1:0];
				end
			end
			tur_pkg::ST_MARK_WR: begin
				wcur_q <= wcur_q + tur_pkg::WADDR_W'(1);
			end
			tur_pkg::ST_SCAN_FETCH: begin
				acc_q <= '0;
			end
			tur_pkg::ST_SCAN_LOAD: begin
				cur_q <= bmp_rdata;
				acc_q <= acc_q + tur_pkg::RANK_W'(tur_pkg::popcount(bmp_rdata));
			end
			tur_pkg::ST_SCAN_RUN: begin
				if (srch.hit && !in_run_q) begin
					run_start_q <= {w_q, srch.idx};
				end
			end
			tur_pkg::ST_REMAP_MAP: begin
				off_q <= ps_x[tur_pkg::BIT_W-1:0];
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_a_q    <= out_a_d;
			out_b_q    <= out_b_d;
			out_ovf_q  <= dropped_q;
			out_last_q <= out_last_d;
		end
	end

	// Piece start store: written on a kept piece, read one entry per remap step
	always_ff @(posedge clk) begin
		if (take_piece) begin
			pstore_mem[count_q[tur_pkg::PIDX_W-1:0]] <= pieces.piece_tile;
		end
		if (state_q == tur_pkg::ST_REMAP_RD) begin
			ps_rd_q <= pstore_mem[p_q[tur_pkg::PIDX_W-1:0]];
		end
	end

	// Rank memory: used tiles below each word, filled during the scan
	always_ff @(posedge clk) begin
		if (state_q == tur_pkg::ST_SCAN_LOAD) begin
			rank_mem[w_q] <= acc_q;
		end
		if (state_q == tur_pkg::ST_REMAP_MAP) begin
			rank_rd_q <= rank_mem[remap_word];
		end
	end

	assign pieces.ready     = (state_q == tur_pkg::ST_IDLE);
	assign results.valid    = out_vld_q;
	assign results.kind     = out_kind_q;
	assign results.value_a  = out_a_q;
	assign results.value_b  = out_b_q;
	assign results.overflow = out_ovf_q;
	assign results.last     = out_last_q;

endmodule

FILE: src/tur_checker.sv
// Port-level checker of the tile usage run extract / remap block and its bind.
module tur_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [tur_pkg::KIND_W-1:0] kind,
	input logic [tur_pkg::VA_W-1:0]   value_a,
	input logic [tur_pkg::VB_W-1:0]   value_b,
	input logic                       overflow,
	input logic                       last
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(value_a) &&
		$stable(value_b) && $stable(overflow) && $stable(last))
		else $error("result beat changed while stalled");

	// Empty frame marker closes its frame and carries zeros
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tur_pkg::KIND_EMPTY |-> last && value_a == '0 && value_b == '0)
		else $error("empty frame marker malformed");

	// Remapped pieces close the frame: no run follows one
	a_remap_tail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == tur_pkg::KIND_REMAP && !last |=>
		!out_valid || kind == tur_pkg::KIND_REMAP)
		else $error("run result after remapped piece");

	// No new piece is taken while a frame's results are still being sent
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> !in_ready)
		else $error("input ready inside a frame's result burst");

endmodule

bind tile_usage_run_extract_remap tur_checker u_tur_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pieces.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.kind      (results.kind),
	.value_a   (results.value_a),
	.value_b   (results.value_b),
	.overflow  (results.overflow),
	.last      (results.last)
);

FILE: tb/tb_top.sv
// Self-checking bench for the tile usage run extract / remap block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// One beat on the piece side
	typedef struct {
		logic                       piece_valid;
		logic [tur_pkg::TILE_W-1:0] tile;
		logic [tur_pkg::WH_W-1:0]   width;
		logic [tur_pkg::WH_W-1:0]   height;
		logic                       frame_end;
	} piece_beat_t;

	// One beat on the result side
	typedef struct {
		tur_pkg::kind_t             kind;
		logic [tur_pkg::VA_W-1:0]   value_a;
		logic [tur_pkg::VB_W-1:0]   value_b;
		logic                       overflow;
		logic                       last;
	} frame_result_t;

	localparam int QUIET_TAIL   = 40;   // beats at the end driven with no idling
	localparam int DRAIN_CYCLES = 300;  // longer than one frame-end pass

	logic clk;
	logic arst_n;

	tur_in_if  pieces_if ();
	tur_out_if results_if ();

	tile_usage_run_extract_remap i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pieces  (pieces_if),
		.results (results_if)
	);

	// Pending stimulus, and results still owed by the block
	piece_beat_t   piece_beats[$];
	frame_result_t expected_results[$];

	// Own copy of the block state
	bit                         usage_map[tur_pkg::MAX_TILES];
	logic [tur_pkg::TILE_W-1:0] kept_starts[tur_pkg::MAX_PIECES];
	int                         kept_count;
	bit                         drop_seen;

	int beats_total;
	int beats_accepted;
	int mismatches;
	bit beat_taken;
	int gap_left;
	int stall_left;

	always #2 clk = ~clk;

	// Append one result of the current frame, honoring the per-frame result cap.
	function automatic void queue_result(tur_pkg::kind_t k, int a, int b, ref int n);
		frame_result_t r;
		if (n < tur_pkg::RESULT_LIMIT) begin
			r.kind     = k;
			r.value_a  = a[tur_pkg::VA_W-1:0];
			r.value_b  = b[tur_pkg::VB_W-1:0];
			r.overflow = drop_seen;
			r.last     = 1'b0;
			expected_results.insert(expected_results.size(), r);
			n++;
		end
	endfunction

	// Mark the tiles of an accepted beat; on frame end, predict the runs and remapped starts.
	task automatic track_tile_usage(input piece_beat_t b);
		int area;
		int n;
		int t;
		int run_start;
		int below;
		if (b.piece_valid) begin
			area = int'(b.width) * int'(b.height);
			if (kept_count >= tur_pkg::MAX_PIECES ||
				int'(b.tile) + area > tur_pkg::MAX_TILES) begin
				drop_seen = 1'b1;
			end else begin
				for (int i = 0; i < area; i++) begin
					usage_map[int'(b.tile) + i] = 1'b1;
				end
				kept_starts[kept_count] = b.tile;
				kept_count++;
			end
		end
		if (b.frame_end) begin
			n = 0;
			if (kept_count == 0) begin
				queue_result(tur_pkg::KIND_EMPTY, 0, 0, n);
			end else begin
				// Runs of used tiles, lowest first; a run touching the top ends there
				t = 0;
				while (t < tur_pkg::MAX_TILES) begin
					if (!usage_map[t]) begin
						t++;
					end else begin
						run_start = t;
						while (t < tur_pkg::MAX_TILES && usage_map[t]) t++;
						queue_result(tur_pkg::KIND_RUN, run_start, t - run_start, n);
					end
				end
				// New start of each kept piece is the number of used tiles below it
				for (int p = 0; p < kept_count; p++) begin
					below = 0;
					for (int k = 0; k < int'(kept_starts[p]); k++) begin
						below += usage_map[k];
					end
					queue_result(tur_pkg::KIND_REMAP, below, p, n);
				end
			end
			expected_results[expected_results.size() - 1].last = 1'b1;
			for (int i = 0; i < tur_pkg::MAX_TILES; i++) usage_map[i] = 1'b0;
			kept_count = 0;
			drop_seen  = 1'b0;
		end
	endtask

	function automatic void add_beat(bit pv, int tile, int w, int h, bit fe);
		piece_beat_t b;
		b.piece_valid = pv;
		b.tile        = tile[tur_pkg::TILE_W-1:0];
		b.width       = w[tur_pkg::WH_W-1:0];
		b.height      = h[tur_pkg::WH_W-1:0];
		b.frame_end   = fe;
		piece_beats.insert(piece_beats.size(), b);
		beats_total++;
	endfunction

	// Sample both channels at the rising edge: predict on accepted pieces, check results.
	always @(posedge clk) begin
		piece_beat_t   b;
		frame_result_t exp_r;
		if (arst_n) begin
			if (pieces_if.valid && pieces_if.ready) begin
				b.piece_valid = pieces_if.piece_valid;
				b.tile        = pieces_if.piece_tile;
				b.width       = pieces_if.piece_width;
				b.height      = pieces_if.piece_height;
				b.frame_end   = pieces_if.frame_end;
				beats_accepted++;
				track_tile_usage(b);
			end
			if (results_if.valid && results_if.ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result beat kind=%0d a=%0d b=%0d ovf=%0b last=%0b",
						$realtime, results_if.kind, results_if.value_a, results_if.value_b,
						results_if.overflow, results_if.last);
				end else begin
					exp_r = expected_results.pop_front();
					if (results_if.kind !== exp_r.kind || results_if.value_a !== exp_r.value_a
						|| results_if.value_b !== exp_r.value_b
						|| results_if.overflow !== exp_r.overflow
						|| results_if.last !== exp_r.last) begin
						mismatches++;
						$display("%0t: mismatch expected %0d %0d %0d %0b %0b, got %0d %0d %0d %0b %0b",
							$realtime, exp_r.kind, exp_r.value_a, exp_r.value_b,
							exp_r.overflow, exp_r.last, results_if.kind,
							results_if.value_a, results_if.value_b,
							results_if.overflow, results_if.last);
					end
				end
			end
		end
		beat_taken = arst_n && pieces_if.valid && pieces_if.ready;
	end

	// Piece driver: hold a beat until taken, insert idle bursts, go steady near the end.
	always @(negedge clk) begin
		piece_beat_t b;
		if (!arst_n) begin
			pieces_if.valid <= 1'b0;
		end else if (pieces_if.valid && !beat_taken) begin
			// hold the current beat
		end else if (gap_left > 0) begin
			pieces_if.valid <= 1'b0;
			gap_left--;
		end else if (piece_beats.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
			pieces_if.valid <= 1'b0;
			gap_left = $urandom_range(0, 13);
		end else if (piece_beats.size() > 0) begin
			b = piece_beats.pop_front();
			pieces_if.valid        <= 1'b1;
			pieces_if.piece_valid  <= b.piece_valid;
			pieces_if.piece_tile   <= b.tile;
			pieces_if.piece_width  <= b.width;
			pieces_if.piece_height <= b.height;
			pieces_if.frame_end    <= b.frame_end;
		end else begin
			pieces_if.valid <= 1'b0;
		end
	end

	// Result side: stall in bursts while plenty of stimulus is left, else stay ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			results_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			results_if.ready <= 1'b0;
			stall_left--;
		end else if (piece_beats.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
			results_if.ready <= 1'b0;
			stall_left = $urandom_range(0, 13);
		end else begin
			results_if.ready <= 1'b1;
		end
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#3_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int frame_len;
		int base;
		int mode;
		int tile;
		int w;
		int h;
		bit ended;

		clk    = 1'b0;
		arst_n = 1'b0;
		pieces_if.valid        = 1'b0;
		pieces_if.piece_valid  = 1'b0;
		pieces_if.piece_tile   = '0;
		pieces_if.piece_width  = '0;
		pieces_if.piece_height = '0;
		pieces_if.frame_end    = 1'b0;
		results_if.ready       = 1'b0;
		kept_count     = 0;
		drop_seen      = 1'b0;
		beats_total    = 0;
		beats_accepted = 0;
		mismatches     = 0;
		beat_taken     = 1'b0;
		gap_left       = 0;
		stall_left     = 0;

		// Directed: empty frame, ignored beat, smallest piece at tile 0
		add_beat(0, 0, 0, 0, 1);
		add_beat(0, 2047, 7, 7, 0);
		add_beat(1, 0, 1, 1, 1);
		// Runs at the top of the map, and a piece running past it
		add_beat(1, 2047, 1, 1, 0);
		add_beat(1, 2043, 4, 1, 0);
		add_beat(1, 2047, 2, 1, 1);
		// Only piece dropped for range: empty marker with overflow
		add_beat(1, 2040, 4, 4, 1);
		// Zero-area pieces and oversize widths/heights, frame closed by a bare end beat
		add_beat(1, 100, 0, 3, 0);
		add_beat(1, 200, 7, 7, 0);
		add_beat(1, 300, 5, 0, 0);
		add_beat(1, 150, 6, 4, 0);
		add_beat(0, 1234, 3, 3, 1);
		// Full piece store, then one too many: 16 runs and 16 remaps
		for (int i = 0; i < tur_pkg::MAX_PIECES; i++) begin
			add_beat(1, 1000 - i * 20, (i % 4) + 1, (i % 2) + 1, 0);
		end
		add_beat(1, 500, 1, 1, 1);

		// Random frames: mostly well-formed clustered pieces, some noise and overruns
		while (beats_total < 250) begin
			frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 19) : $urandom_range(0, 6);
			base = ($urandom_range(0, 4) == 0) ? $urandom_range(1990, 2047)
				: $urandom_range(0, 1990);
			ended = 1'b0;
			for (int k = 0; k < frame_len; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					add_beat(0, $urandom, $urandom_range(0, 7), $urandom_range(0, 7), 0);
				end
				mode = $urandom_range(0, 9);
				tile = (mode == 0) ? $urandom_range(0, 2047) : base + $urandom_range(0, 40);
				if (tile > 2047) tile = 2047;
				w = (mode == 1) ? $urandom_range(0, 7) : $urandom_range(1, 4);
				h = (mode == 2) ? $urandom_range(0, 7) : $urandom_range(1, 4);
				ended = (k == frame_len - 1) && $urandom_range(0, 1);
				add_beat(1, tile, w, h, ended);
			end
			if (!ended) begin
				add_beat(0, $urandom, $urandom_range(0, 7), $urandom_range(0, 7), 1);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every beat to be taken, then for every owed result, then drain
		while (beats_accepted != beats_total) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
src/tur_pkg.sv
src/tur_if.sv
src/tur_bitmap.sv
src/tile_usage_run_extract_remap.sv
src/tur_checker.sv
tb/tb_top.sv
